// ----- hdl/ffha_pkg.sv -----
// Shared constants, codes and types of the first-fit heap allocator.
// No dependencies; every other file imports it.
`default_nettype none
package ffha_pkg;

	localparam int MAX_CHUNKS   = 256;
	localparam int HEADER_BYTES = 16;
	localparam int OFF_W        = 20;
	localparam int SIZE_W       = 21;
	localparam int ADDR_W       = 32;
	localparam int DATA_W       = 32;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOFIT   = 2'd1;
	localparam logic [1:0] STAT_UNKNOWN = 2'd2;

	localparam logic REG_HEAP_BASE = 1'b0;
	localparam logic REG_HEAP_SIZE = 1'b1;

	typedef enum logic [1:0] {
		SHIFT_NONE = 2'd0,
		SHIFT_ONE  = 2'd1,
		SHIFT_TWO  = 2'd2
	} shift_t;

	typedef struct packed {
		logic              v;
		logic              used;
		logic [OFF_W-1:0]  off;
		logic [SIZE_W-1:0] bytes;
	} entry_t;

	typedef struct packed {
		logic              act;
		logic              func;
		logic [SIZE_W-1:0] req;
		logic [OFF_W-1:0]  tgt;
		logic              tgt_ok;
		logic              full;
		logic              found;
		logic              carry_on;
		entry_t            carry;
		shift_t            shift;
		logic [1:0]        status;
		logic [OFF_W-1:0]  hit_off;
	} pkt_t;

endpackage
`default_nettype wire

// ----- hdl/ffha_cell.sv -----
// One table cell: holds a chunk entry and the request packet that just passed it.
// Depends on ffha_pkg.
`default_nettype none
module ffha_cell
	import ffha_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   init,
	input  wire entry_t init_ent,
	input  wire pkt_t   pin,
	input  wire entry_t n1,
	input  wire entry_t n2,
	output entry_t      ent,
	output pkt_t        pout
);

	entry_t ent_q;
	pkt_t   pkt_q;
	entry_t e_d;
	pkt_t   p_d;

	logic [SIZE_W:0]   need;
	logic              split;
	logic              m1;
	logic              m2;
	logic [SIZE_W-1:0] hdr;
	logic [SIZE_W-1:0] sum1;
	logic [SIZE_W-1:0] sum2;

	always_comb begin
		hdr   = SIZE_W'(HEADER_BYTES);
		need  = {1'b0, pin.req} + (SIZE_W+1)'(HEADER_BYTES + 1);
		split = {1'b0, ent_q.bytes} >= need;
		m1    = n1.v && !n1.used;
		m2    = n2.v && !n2.used;
		sum1  = ent_q.bytes + n1.bytes + hdr;
		sum2  = sum1 + (m2 ? n2.bytes + hdr : '0);
		e_d   = ent_q;
		p_d   = pin;
		if (pin.act) begin
			if (pin.func == FUNC_ALLOC) begin
				if (pin.carry_on) begin
					e_d        = pin.carry;
					p_d.carry  = ent_q;
					p_d.carry_on = ent_q.v;
				end else if (!pin.found && ent_q.v && !ent_q.used &&
						ent_q.bytes > pin.req) begin
					p_d.found = 1'b1;
					if (!(split && pin.full)) begin
						p_d.status  = STAT_OK;
						p_d.hit_off = ent_q.off;
						e_d.used    = 1'b1;
						if (split) begin
							e_d.bytes      = pin.req;
							p_d.carry_on   = 1'b1;
							p_d.carry.v    = 1'b1;
							p_d.carry.used = 1'b0;
							p_d.carry.off  = ent_q.off + OFF_W'(HEADER_BYTES) +
								pin.req[OFF_W-1:0];
							p_d.carry.bytes = ent_q.bytes - pin.req - hdr;
						end
					end
				end
			end else begin
				case (pin.shift)
					SHIFT_ONE: e_d = n1;
					SHIFT_TWO: e_d = n2;
					default: begin
						if (!pin.found && pin.tgt_ok && ent_q.v && ent_q.off == pin.tgt) begin
							p_d.found  = 1'b1;
							p_d.status = STAT_OK;
							e_d.used   = 1'b0;
							if (m1) begin
								e_d.bytes = sum1;
								p_d.shift = SHIFT_ONE;
							end
						end else if (!pin.found && pin.tgt_ok && n1.v &&
								n1.off == pin.tgt && ent_q.v && !ent_q.used) begin
							p_d.found  = 1'b1;
							p_d.status = STAT_OK;
							e_d.bytes  = sum2;
							p_d.shift  = m2 ? SHIFT_TWO : SHIFT_ONE;
						end
					end
				endcase
			end
		end
		if (init) begin
			e_d = init_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			pkt_q <= '0;
		end else begin
			ent_q <= e_d;
			pkt_q <= p_d;
		end
	end

	assign ent  = ent_q;
	assign pout = pkt_q;

endmodule
`default_nettype wire

// ----- hdl/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator: controller, configuration registers and the row of cells.
// Depends on ffha_pkg and ffha_cell.
//
// A request is taken when start is high and busy is low. It travels as a packet
// through the 256 table cells, one cell per clock, and each cell searches, splits,
// marks or merges its own entry and shifts entries in from its neighbors. The
// result is registered after the packet leaves the last cell, with done high for
// exactly one cycle; the receiver cannot stall it. busy is high from the accepting edge
// until the result cycle. Write registers only while busy is low.
`default_nettype none
module first_fit_heap_allocator_top
	import ffha_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              func,
	input  wire logic [SIZE_W-1:0] request_size,
	input  wire logic [ADDR_W-1:0] block_address,
	output logic                   done,
	output logic [ADDR_W-1:0]      granted_address,
	output logic [1:0]             status
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] heap_base_q;
	pkt_t              launch_q;
	pkt_t              launch_d;
	logic              done_q;
	logic [ADDR_W-1:0] grant_q;
	logic [1:0]        status_q;

	entry_t            ents [MAX_CHUNKS];
	pkt_t              pkts [MAX_CHUNKS];
	logic              init;
	entry_t            init_ent;
	logic [SIZE_W-1:0] sz;
	logic [ADDR_W-1:0] tgt;
	pkt_t              last;

	assign init = wr_en && wr_index == REG_HEAP_SIZE;
	assign last = pkts[MAX_CHUNKS-1];

	always_comb begin
		sz = (wr_data[SIZE_W-1:0] > SIZE_W'(1 << OFF_W)) ? SIZE_W'(1 << OFF_W) :
			wr_data[SIZE_W-1:0];
		init_ent.v     = sz >= SIZE_W'(HEADER_BYTES);
		init_ent.used  = 1'b0;
		init_ent.off   = '0;
		init_ent.bytes = sz - SIZE_W'(HEADER_BYTES);
	end

	always_comb begin
		tgt               = block_address - heap_base_q - ADDR_W'(HEADER_BYTES);
		launch_d          = '0;
		launch_d.act      = start && state_q == ST_IDLE;
		launch_d.func     = func;
		launch_d.req      = request_size;
		launch_d.tgt      = tgt[OFF_W-1:0];
		launch_d.tgt_ok   = tgt[ADDR_W-1:OFF_W] == '0;
		launch_d.full     = ents[MAX_CHUNKS-1].v;
		launch_d.shift    = SHIFT_NONE;
		launch_d.status   = (func == FUNC_FREE) ? STAT_UNKNOWN : STAT_NOFIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			heap_base_q <= '0;
			launch_q    <= '0;
			done_q      <= 1'b0;
			grant_q     <= '0;
			status_q    <= STAT_OK;
		end else begin
			launch_q <= launch_d;
			done_q   <= last.act;
			if (wr_en && wr_index == REG_HEAP_BASE) begin
				heap_base_q <= wr_data[ADDR_W-1:0];
			end
			if (last.act) begin
				status_q <= last.status;
				grant_q  <= (last.func == FUNC_ALLOC && last.status == STAT_OK) ?
					heap_base_q + ADDR_W'(last.hit_off) + ADDR_W'(HEADER_BYTES) : '0;
			end
			case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_BUSY;
				end
				ST_BUSY: if (last.act) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	for (genvar k = 0; k < MAX_CHUNKS; k++) begin : g_cell
		pkt_t   pin_k;
		entry_t n1_k;
		entry_t n2_k;
		entry_t ie_k;
		if (k == 0) begin : g_first
			assign pin_k = launch_q;
			assign ie_k  = init_ent;
		end else begin : g_rest
			assign pin_k = pkts[k-1];
			assign ie_k  = '0;
		end
		if (k + 1 < MAX_CHUNKS) begin : g_n1
			assign n1_k = ents[k+1];
		end else begin : g_n1_end
			assign n1_k = '0;
		end
		if (k + 2 < MAX_CHUNKS) begin : g_n2
			assign n2_k = ents[k+2];
		end else begin : g_n2_end
			assign n2_k = '0;
		end
		ffha_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.init     (init),
			.init_ent (ie_k),
			.pin      (pin_k),
			.n1       (n1_k),
			.n2       (n2_k),
			.ent      (ents[k]),
			.pout     (pkts[k])
		);
	end

	assign busy            = state_q == ST_BUSY;
	assign done            = done_q;
	assign granted_address = grant_q;
	assign status          = status_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> granted_address == '0)
		else $error("address on failed request");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without start");
`endif

endmodule
`default_nettype wire

// ----- tb/first_fit_heap_allocator_checker.sv -----
`timescale 1ns / 1ps
// Checker for the first-fit heap allocator: tracks the chunk table, predicts each result
// and compares it with the done transfer. Depends on ffha_pkg.
module first_fit_heap_allocator_checker
	import ffha_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              func,
	input  wire logic [SIZE_W-1:0] request_size,
	input  wire logic [ADDR_W-1:0] block_address,
	input  wire logic              done,
	input  wire logic [ADDR_W-1:0] granted_address,
	input  wire logic [1:0]        status,
	output int                     errors,
	output int                     outstanding
);

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        stat;
	} grant_t;

	logic [OFF_W-1:0]  chunk_off[MAX_CHUNKS];
	logic [SIZE_W-1:0] chunk_len[MAX_CHUNKS];
	bit                chunk_busy[MAX_CHUNKS];
	int                chunk_num;
	logic [ADDR_W-1:0] base_q;
	grant_t            grant_q[$];

	assign outstanding = grant_q.size();

	function automatic void table_init(logic [SIZE_W-1:0] sz);
		logic [SIZE_W-1:0] s;
		s = (sz > (1 << OFF_W)) ? SIZE_W'(1 << OFF_W) : sz;
		if (s < HEADER_BYTES) begin
			chunk_num = 0;
		end else begin
			chunk_off[0] = '0;
			chunk_len[0] = s - SIZE_W'(HEADER_BYTES);
			chunk_busy[0] = 0;
			chunk_num = 1;
		end
	endfunction

	function automatic void drop_chunk(int pos);
		for (int j = pos; j + 1 < chunk_num; j++) begin
			chunk_off[j] = chunk_off[j+1];
			chunk_len[j] = chunk_len[j+1];
			chunk_busy[j] = chunk_busy[j+1];
		end
		chunk_num--;
	endfunction

	function automatic grant_t heap_op(logic f, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] a);
		grant_t g;
		int i;
		logic [ADDR_W-1:0] tgt;
		g.addr = '0;
		g.stat = STAT_OK;
		i = -1;
		if (f == FUNC_ALLOC) begin
			for (int k = 0; k < chunk_num; k++)
				if (i < 0 && !chunk_busy[k] && chunk_len[k] > req) i = k;
			if (i < 0) begin
				g.stat = STAT_NOFIT;
				return g;
			end
			if (23'(chunk_len[i]) >= 23'(req) + HEADER_BYTES + 1) begin
				if (chunk_num >= MAX_CHUNKS) begin
					g.stat = STAT_NOFIT;
					return g;
				end
				for (int j = chunk_num; j > i + 1; j--) begin
					chunk_off[j] = chunk_off[j-1];
					chunk_len[j] = chunk_len[j-1];
					chunk_busy[j] = chunk_busy[j-1];
				end
				chunk_off[i+1] = chunk_off[i] + OFF_W'(HEADER_BYTES) + OFF_W'(req);
				chunk_len[i+1] = chunk_len[i] - req - SIZE_W'(HEADER_BYTES);
				chunk_busy[i+1] = 0;
				chunk_num++;
				chunk_len[i] = req;
			end
			chunk_busy[i] = 1;
			g.addr = base_q + ADDR_W'(chunk_off[i]) + ADDR_W'(HEADER_BYTES);
			return g;
		end
		tgt = a - base_q - ADDR_W'(HEADER_BYTES);
		for (int k = 0; k < chunk_num; k++)
			if (i < 0 && ADDR_W'(chunk_off[k]) == tgt) i = k;
		if (i < 0) begin
			g.stat = STAT_UNKNOWN;
			return g;
		end
		chunk_busy[i] = 0;
		if (i > 0 && !chunk_busy[i-1]) begin
			chunk_len[i-1] = chunk_len[i-1] + chunk_len[i] + SIZE_W'(HEADER_BYTES);
			drop_chunk(i);
			i--;
		end
		if (i + 1 < chunk_num && !chunk_busy[i+1]) begin
			chunk_len[i] = chunk_len[i] + chunk_len[i+1] + SIZE_W'(HEADER_BYTES);
			drop_chunk(i + 1);
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			base_q <= '0;
			chunk_num = 0;
			errors <= 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_HEAP_BASE) base_q <= wr_data;
				else table_init(wr_data[SIZE_W-1:0]);
			end
			if (start && !busy) grant_q.push_back(heap_op(func, request_size, block_address));
			if (done) begin
				if (grant_q.size() == 0) begin
					$display("%t: unexpected result addr=%h status=%0d",
						$time, granted_address, status);
					errors <= errors + 1;
				end else begin
					want = grant_q.pop_front();
					if (want.addr !== granted_address || want.stat !== status) begin
						$display("%t: mismatch expected addr=%h status=%0d actual addr=%h status=%0d",
							$time, want.addr, want.stat, granted_address, status);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ----- tb/first_fit_heap_allocator_top_test.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the first-fit heap allocator.
// Depends on ffha_pkg, first_fit_heap_allocator_top and first_fit_heap_allocator_checker.
module first_fit_heap_allocator_top_test;
	import ffha_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              wr_en = 0;
	logic              wr_index = REG_HEAP_BASE;
	logic [DATA_W-1:0] wr_data = '0;
	logic              start = 0;
	logic              busy;
	logic              func = FUNC_ALLOC;
	logic [SIZE_W-1:0] request_size = '0;
	logic [ADDR_W-1:0] block_address = '0;
	logic              done;
	logic [ADDR_W-1:0] granted_address;
	logic [1:0]        status;
	int                errors;
	int                outstanding;
	int                idle_pct;
	logic [ADDR_W-1:0] live_addrs[$];
	logic [ADDR_W-1:0] last_grant;

	always #5 clk = ~clk;

	first_fit_heap_allocator_top dut (.*);
	first_fit_heap_allocator_checker chk (.*);

	task automatic write_reg(logic idx, logic [DATA_W-1:0] val);
		wait (outstanding == 0);
		@(negedge clk);
		while (busy) @(negedge clk);
		repeat (260) @(negedge clk);
		wr_en = 1;
		wr_index = idx;
		wr_data = val;
		@(negedge clk);
		wr_en = 0;
		live_addrs.delete();
	endtask

	task automatic transfer(logic f, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] a);
		@(negedge clk);
		while (busy || $urandom_range(99) < idle_pct) @(negedge clk);
		start = 1;
		func = f;
		request_size = req;
		block_address = a;
		@(negedge clk);
		start = 0;
		while (!done) @(negedge clk);
		last_grant = granted_address;
		if (f == FUNC_ALLOC && status == STAT_OK) live_addrs.push_back(granted_address);
	endtask

	task automatic free_live(int idx);
		logic [ADDR_W-1:0] a;
		a = live_addrs[idx];
		live_addrs.delete(idx);
		transfer(FUNC_FREE, '0, a);
	endtask

	task automatic random_item();
		if ($urandom_range(1) == 0 || live_addrs.size() == 0) begin
			if ($urandom_range(9) == 0)
				transfer(FUNC_ALLOC, SIZE_W'($urandom_range(1 << OFF_W)), $urandom);
			else
				transfer(FUNC_ALLOC, SIZE_W'($urandom_range(3000)), $urandom);
		end else if ($urandom_range(9) == 0) begin
			transfer(FUNC_FREE, SIZE_W'($urandom), $urandom);
		end else begin
			free_live($urandom_range(live_addrs.size() - 1));
		end
	endtask

	initial begin
		idle_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		transfer(FUNC_ALLOC, 21'd0, '0);
		write_reg(REG_HEAP_SIZE, 32'd5);
		transfer(FUNC_ALLOC, 21'd0, '0);
		write_reg(REG_HEAP_BASE, 32'hFFFF_FFF8);
		write_reg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
		transfer(FUNC_ALLOC, 21'd0, '0);
		transfer(FUNC_ALLOC, 21'd1048576, '0);
		transfer(FUNC_ALLOC, 21'd100, '0);
		transfer(FUNC_ALLOC, 21'd1048000, '0);
		free_live(1);
		transfer(FUNC_FREE, '0, last_grant);
		transfer(FUNC_FREE, '0, 32'h1234_5677);
		transfer(FUNC_FREE, '0, 32'hFFFF_FFFF);
		free_live(0);
		write_reg(REG_HEAP_SIZE, 32'd48);
		transfer(FUNC_ALLOC, 21'd20, '0);
		transfer(FUNC_ALLOC, 21'd31, '0);
		transfer(FUNC_ALLOC, 21'd32, '0);
		transfer(FUNC_FREE, '0, last_grant);
		write_reg(REG_HEAP_SIZE, 32'd16);
		transfer(FUNC_ALLOC, 21'd0, '0);
		write_reg(REG_HEAP_SIZE, 32'd17);
		transfer(FUNC_ALLOC, 21'd0, '0);

		for (int mode = 0; mode < 3; mode++) begin
			idle_pct = (mode == 0) ? 6 : (mode == 1) ? 71 : 0;
			write_reg(REG_HEAP_BASE, $urandom);
			write_reg(REG_HEAP_SIZE, (mode == 2) ? 32'd1048576 : 32'($urandom_range(20000, 300000)));
			if (mode == 2) begin
				repeat (270) transfer(FUNC_ALLOC, SIZE_W'($urandom_range(8)), '0);
				repeat (40) free_live($urandom_range(live_addrs.size() - 1));
				repeat (5) transfer(FUNC_ALLOC, SIZE_W'($urandom_range(8)), '0);
			end
			repeat (190) random_item();
		end
		write_reg(REG_HEAP_BASE, '0);

		wait (outstanding == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#30ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ffha_pkg.sv
hdl/ffha_cell.sv
hdl/first_fit_heap_allocator_top.sv
tb/first_fit_heap_allocator_checker.sv
tb/first_fit_heap_allocator_top_test.sv
